// File: src/fba_pkg.sv
// Shared constants, codes and types of the frame bitmap allocator.
package fba_pkg;

   localparam int NUM_FRAMES     = 4096;
   localparam int WORD_BITS      = 32;
   localparam int MAP_WORDS      = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W     = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W      = $clog2(WORD_BITS);
   localparam int FRAME_W        = 12;
   localparam int COUNT_W        = 13;
   localparam int GROUP_SIZE     = 8;
   localparam int NUM_GROUPS     = MAP_WORDS / GROUP_SIZE;
   localparam int GROUP_IDX_W    = $clog2(NUM_GROUPS);
   localparam int MEMBER_W       = $clog2(GROUP_SIZE);

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(NUM_FRAMES);

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_CHECK = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_code_type;

   // Write-back notice from the controller to the free-word search.
   typedef struct packed {
      logic                  valid;
      logic [WORD_IDX_W-1:0] word;
      logic                  full;
   } map_update_type;

endpackage

// File: src/fba_bitmap_ram.sv
// Simple dual-port synchronous RAM (one read port, one write port) with registered read data.
module fba_bitmap_ram #(
   parameter int ADDR_W = 7,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/fba_free_search.sv
// Per-word full summary and two-level search for the lowest non-full word.
module fba_free_search (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  fba_pkg::map_update_type            update,
   output logic                               found,
   output logic [fba_pkg::WORD_IDX_W-1:0]     word
);

   logic [fba_pkg::MAP_WORDS-1:0]  full_ff;
   logic [fba_pkg::NUM_GROUPS-1:0] grp_any_ff;
   logic [fba_pkg::NUM_GROUPS-1:0] grp_any_in;
   logic [fba_pkg::MEMBER_W-1:0]   grp_idx_ff [fba_pkg::NUM_GROUPS];
   logic [fba_pkg::MEMBER_W-1:0]   grp_idx_in [fba_pkg::NUM_GROUPS];

   // First level: lowest non-full member of each group of words.
   always_comb begin
      for (int g = 0; g < fba_pkg::NUM_GROUPS; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int m = fba_pkg::GROUP_SIZE - 1; m >= 0; m--) begin
            if (!full_ff[g * fba_pkg::GROUP_SIZE + m]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = fba_pkg::MEMBER_W'(m);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff    <= '0;
         grp_any_ff <= '0;
      end else begin
         if (update.valid) begin
            full_ff[update.word] <= update.full;
         end
         if (start) begin
            grp_any_ff <= grp_any_in;
         end
      end
      if (start) begin
         grp_idx_ff <= grp_idx_in;
      end
   end

   // Second level: lowest group that still has room.
   always_comb begin
      found = 1'b0;
      word  = '0;
      for (int g = fba_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found = 1'b1;
            word  = {fba_pkg::GROUP_IDX_W'(g), grp_idx_ff[g]};
         end
      end
   end

endmodule

// File: src/frame_bitmap_allocator_core.sv
// Frame bitmap allocator: first-fit allocate, free and check over a used-frame bitmap.
// Allocate passes through the search and read states from accept to response; free and check
// go straight to the read state. One request is taken at a time: a new one is accepted only
// when idle, after the response of the last one has been registered.
// Reset: synchronous; all frames free at once (per-word valid bits), frame_count = 4096.
// Responses sit in an output register; a stalled response holds the next write-back.
module frame_bitmap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] frame_number, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] result_frame, [12] frame_in_use, [15:13] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_wdata    // [12:0] frame_count
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_READ
   } state_type;

   state_type                             state_ff, state_in;
   logic [fba_pkg::COUNT_W-1:0]           frame_count_ff;
   logic [fba_pkg::COUNT_W-1:0]           eff_count;
   logic [fba_pkg::MAP_WORDS-1:0]         word_valid_ff;
   logic [1:0]                            op_ff;
   logic [fba_pkg::FRAME_W-1:0]           fn_ff;
   logic                                  range_ff;
   logic [fba_pkg::WORD_IDX_W-1:0]        word_ff;
   logic                                  found_ff;
   logic                                  rd_valid_ff;

   logic                                  req_xfer;
   logic                                  search_start;
   logic                                  search_found;
   logic [fba_pkg::WORD_IDX_W-1:0]        search_word;
   fba_pkg::map_update_type               map_update;

   logic                                  rd_en;
   logic [fba_pkg::WORD_IDX_W-1:0]        rd_addr;
   logic [fba_pkg::WORD_BITS-1:0]         ram_q;
   logic [fba_pkg::WORD_BITS-1:0]         word_data;
   logic                                  wr_en;
   logic [fba_pkg::WORD_BITS-1:0]         wr_data;

   logic                                  zero_any;
   logic [fba_pkg::BIT_IDX_W-1:0]         zero_bit;
   logic [fba_pkg::BIT_IDX_W-1:0]         bit_sel;
   logic [fba_pkg::WORD_BITS-1:0]         bit_mask;
   logic [fba_pkg::FRAME_W-1:0]           alloc_frame;
   logic                                  alloc_hit;
   logic                                  finish;

   logic                                  rsp_valid_ff;
   logic [fba_pkg::FRAME_W-1:0]           rsp_frame_ff, rsp_frame_in;
   logic [1:0]                            rsp_status_ff, rsp_status_in;
   logic                                  rsp_use_ff, rsp_use_in;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign eff_count  = (frame_count_ff > fba_pkg::COUNT_MAX) ? fba_pkg::COUNT_MAX
                                                             : frame_count_ff;
   assign search_start = req_xfer && (req_tuser == fba_pkg::REQ_ALLOC);

   fba_free_search u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (search_start),
      .update (map_update),
      .found  (search_found),
      .word   (search_word)
   );

   // Read the word of the requested frame on accept, or the searched word after search.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = search_word;
      if (state_ff == S_SEARCH) begin
         rd_en = 1'b1;
      end else if (req_xfer && req_tuser != fba_pkg::REQ_ALLOC) begin
         rd_en   = 1'b1;
         rd_addr = req_tdata[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
      end
   end

   fba_bitmap_ram #(
      .ADDR_W (fba_pkg::WORD_IDX_W),
      .DATA_W (fba_pkg::WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data)
   );

   // A word never written reads as all free.
   assign word_data = rd_valid_ff ? ram_q : '0;

   always_comb begin
      zero_any = 1'b0;
      zero_bit = '0;
      for (int b = fba_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (!word_data[b]) begin
            zero_any = 1'b1;
            zero_bit = fba_pkg::BIT_IDX_W'(b);
         end
      end
   end

   assign alloc_frame = {word_ff, zero_bit};
   assign alloc_hit   = found_ff && zero_any &&
                        ({1'b0, alloc_frame} < eff_count);
   assign bit_sel     = (op_ff == fba_pkg::REQ_ALLOC) ? zero_bit
                                                      : fn_ff[fba_pkg::BIT_IDX_W-1:0];
   assign bit_mask    = fba_pkg::WORD_BITS'(1) << bit_sel;
   assign finish      = (state_ff == S_READ) && (!rsp_valid_ff || rsp_tready);

   // Modify the word and form the response.
   always_comb begin
      wr_en         = 1'b0;
      wr_data       = word_data;
      rsp_frame_in  = fn_ff;
      rsp_status_in = fba_pkg::ST_OK;
      rsp_use_in    = 1'b0;
      unique case (op_ff)
         fba_pkg::REQ_ALLOC: begin
            if (alloc_hit) begin
               wr_en        = finish;
               wr_data      = word_data | bit_mask;
               rsp_frame_in = alloc_frame;
               rsp_use_in   = 1'b1;
            end else begin
               rsp_frame_in  = '0;
               rsp_status_in = fba_pkg::ST_FULL;
            end
         end
         fba_pkg::REQ_FREE: begin
            if (range_ff) begin
               rsp_status_in = fba_pkg::ST_RANGE;
            end else begin
               wr_en   = finish;
               wr_data = word_data & ~bit_mask;
            end
         end
         default: begin
            if (range_ff) begin
               rsp_status_in = fba_pkg::ST_RANGE;
            end else begin
               rsp_use_in = word_data[bit_sel];
            end
         end
      endcase
   end

   assign map_update.valid = wr_en;
   assign map_update.word  = word_ff;
   assign map_update.full  = &wr_data;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = (req_tuser == fba_pkg::REQ_ALLOC) ? S_SEARCH : S_READ;
            end
         end
         S_SEARCH: state_in = S_READ;
         S_READ: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         frame_count_ff <= fba_pkg::COUNT_RESET;
         word_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            frame_count_ff <= csr_wdata;
         end
         if (wr_en) begin
            word_valid_ff[word_ff] <= 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_xfer) begin
         op_ff    <= req_tuser;
         fn_ff    <= req_tdata[fba_pkg::FRAME_W-1:0];
         range_ff <= ({1'b0, req_tdata[fba_pkg::FRAME_W-1:0]} >= eff_count);
         word_ff  <= req_tdata[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
         found_ff <= 1'b1;
      end
      if (state_ff == S_SEARCH) begin
         word_ff  <= search_word;
         found_ff <= search_found;
      end
      if (rd_en) begin
         rd_valid_ff <= word_valid_ff[rd_addr];
      end
      if (finish) begin
         rsp_frame_ff  <= rsp_frame_in;
         rsp_status_ff <= rsp_status_in;
         rsp_use_ff    <= rsp_use_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_use_ff, rsp_frame_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_write_only_at_finish: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> finish)
      else $error("bitmap write outside the finishing cycle");

   a_full_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == fba_pkg::ST_FULL) |-> (rsp_tdata == 16'h0000))
      else $error("full response carries a nonzero frame or used bit");

   a_range_not_used: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == fba_pkg::ST_RANGE) |-> !rsp_tdata[fba_pkg::FRAME_W])
      else $error("out-of-range response reports the frame in use");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("second request taken while one is in progress");

   a_alloc_sets_bit: assert property (@(posedge clock) disable iff (reset)
      (finish && op_ff == fba_pkg::REQ_ALLOC && alloc_hit) |-> (wr_en && (wr_data & bit_mask) != '0))
      else $error("allocation did not mark its frame used");

endmodule
